/* src/c3mf_pkg.sv */
// Shared constants, codes and control/status types for the 3x3 convolution block.
`timescale 1ns / 1ps
package c3mf_pkg;

	localparam int DW          = 16;  // data, coefficient and result width
	localparam int KSIZE       = 3;
	localparam int KTAPS       = KSIZE * KSIZE;
	localparam int CH_W        = 8;   // channel counter
	localparam int POS_W       = 12;  // row and column counters
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_IDX_W   = 3;

	localparam int DEF_LANES        = 8;
	localparam int DEF_MAX_CHANNELS = 256;
	localparam int DEF_LINE_WORDS   = 4096;
	localparam int DEF_FRAC_BITS    = 8;

	localparam logic [1:0] REQ_BIAS  = 2'd0;
	localparam logic [1:0] REQ_COEF  = 2'd1;
	localparam logic [1:0] REQ_PIXEL = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_CH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FILTERS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RELU     = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_BIAS,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic accept;    // input transfer this cycle
		logic issue;     // send one tap down the MAC pipeline
		logic add_bias;  // finish accumulators
		logic lane_clr;
		logic lane_inc;
	} ctl_t;

	typedef struct packed {
		logic fire;      // accepted pixel completes an output position
		logic tap_last;
		logic lane_last;
	} stat_t;

endpackage

/* src/conv3x3_multi_filter_relu.sv */
// Top level of the multi-filter 3x3 convolution with bias and optional ReLU.
`timescale 1ns / 1ps
// Bias and coefficient items and pixels that complete no output position are taken
// while idle. A pixel that completes a position (row and column 2 or more, last
// channel) starts compute: the single read port of the line store feeds one tap per
// cycle to all filter lanes at once, then the pipeline drains, bias is added and
// one result per active filter follows, one per cycle while out_ready is high;
// no input is taken meanwhile. Line addresses column*channels+channel wrap modulo
// LINE_WORDS, which must be a power of two. Write configuration only while idle.
module conv3x3_multi_filter_relu #(
	parameter int LANES        = c3mf_pkg::DEF_LANES,
	parameter int MAX_CHANNELS = c3mf_pkg::DEF_MAX_CHANNELS,
	parameter int LINE_WORDS   = c3mf_pkg::DEF_LINE_WORDS,
	parameter int FRAC_BITS    = c3mf_pkg::DEF_FRAC_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [c3mf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [c3mf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      req_type,
	input  logic [2:0]                      filter_sel,
	input  logic [11:0]                     coef_index,
	input  logic signed [c3mf_pkg::DW-1:0]  data_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [2:0]                      filter_id,
	output logic [11:0]                     out_row,
	output logic [11:0]                     out_col,
	output logic signed [c3mf_pkg::DW-1:0]  out_value,
	output logic                            last_of_position
);

	c3mf_pkg::ctl_t  ctl;
	c3mf_pkg::stat_t stat;

	c3mf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	c3mf_dp #(
		.LANES        (LANES),
		.MAX_CHANNELS (MAX_CHANNELS),
		.LINE_WORDS   (LINE_WORDS),
		.FRAC_BITS    (FRAC_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.req_type         (req_type),
		.filter_sel       (filter_sel),
		.coef_index       (coef_index),
		.data_value       (data_value),
		.filter_id        (filter_id),
		.out_row          (out_row),
		.out_col          (out_col),
		.out_value        (out_value),
		.last_of_position (last_of_position),
		.ctl              (ctl),
		.stat             (stat)
	);

	// input side closed while results are pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input open during result transfer");

	// last result of a position ends the burst
	a_burst_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_of_position |=> !out_valid && in_ready)
		else $error("results continue past last of position");

	// a stalled result keeps its lane and value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(filter_id) && $stable(out_value))
		else $error("stalled result changed");

	// a completing pixel starts computation, not another transfer
	a_fire: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && stat.fire |=> !in_ready && !out_valid)
		else $error("computation did not start");

endmodule

/* src/c3mf_ctrl.sv */
// Sequencer for loads, tap issue, pipeline drain, bias and result transfers.
`timescale 1ns / 1ps
module c3mf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  c3mf_pkg::stat_t stat,
	output c3mf_pkg::ctl_t  ctl
);

	c3mf_pkg::state_t state_q, state_d;
	logic [1:0] dcnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= c3mf_pkg::ST_IDLE;
			dcnt_q  <= 2'd0;
		end else begin
			state_q <= state_d;
			if (state_q == c3mf_pkg::ST_DRAIN) dcnt_q <= dcnt_q + 2'd1;
			else dcnt_q <= 2'd0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			c3mf_pkg::ST_IDLE:  if (in_valid && stat.fire) state_d = c3mf_pkg::ST_ISSUE;
			c3mf_pkg::ST_ISSUE: if (stat.tap_last) state_d = c3mf_pkg::ST_DRAIN;
			// wait until the last product lands in the accumulators
			c3mf_pkg::ST_DRAIN: if (dcnt_q == 2'd2) state_d = c3mf_pkg::ST_BIAS;
			c3mf_pkg::ST_BIAS:  state_d = c3mf_pkg::ST_EMIT;
			c3mf_pkg::ST_EMIT:  if (out_ready && stat.lane_last) state_d = c3mf_pkg::ST_IDLE;
			default:            state_d = c3mf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == c3mf_pkg::ST_IDLE);
		out_valid    = (state_q == c3mf_pkg::ST_EMIT);
		ctl.accept   = in_ready && in_valid;
		ctl.issue    = (state_q == c3mf_pkg::ST_ISSUE);
		ctl.add_bias = (state_q == c3mf_pkg::ST_BIAS);
		ctl.lane_clr = (state_q == c3mf_pkg::ST_BIAS);
		ctl.lane_inc = out_valid && out_ready;
	end

endmodule

/* src/c3mf_dp.sv */
// Datapath: config registers, counters, line and weight memories, MAC lanes, results.
`timescale 1ns / 1ps
module c3mf_dp #(
	parameter int LANES        = c3mf_pkg::DEF_LANES,
	parameter int MAX_CHANNELS = c3mf_pkg::DEF_MAX_CHANNELS,
	parameter int LINE_WORDS   = c3mf_pkg::DEF_LINE_WORDS,
	parameter int FRAC_BITS    = c3mf_pkg::DEF_FRAC_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [c3mf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [c3mf_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [1:0]                        req_type,
	input  logic [2:0]                        filter_sel,
	input  logic [11:0]                       coef_index,
	input  logic signed [c3mf_pkg::DW-1:0]    data_value,
	output logic [2:0]                        filter_id,
	output logic [11:0]                       out_row,
	output logic [11:0]                       out_col,
	output logic signed [c3mf_pkg::DW-1:0]    out_value,
	output logic                              last_of_position,
	input  c3mf_pkg::ctl_t                    ctl,
	output c3mf_pkg::stat_t                   stat
);

	localparam int DW     = c3mf_pkg::DW;
	localparam int FWORDS = MAX_CHANNELS * c3mf_pkg::KTAPS;
	localparam int WA_W   = $clog2(FWORDS);
	localparam int LA_W   = $clog2(LINE_WORDS);  // line address wraps modulo 2**LA_W
	localparam int NCH_W  = $clog2(MAX_CHANNELS + 1);
	localparam int LN_W   = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int NF_W   = $clog2(LANES + 1);
	localparam int POS_W  = c3mf_pkg::POS_W;
	localparam int CH_W   = c3mf_pkg::CH_W;
	localparam logic [1:0] KMAX = 2'(c3mf_pkg::KSIZE - 1);

	// configuration
	logic [8:0]  ncfg_q;
	logic [12:0] wcfg_q, hcfg_q;
	logic [3:0]  fcfg_q;
	logic        relu_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncfg_q <= 9'd1;
			wcfg_q <= 13'd3;
			hcfg_q <= 13'd3;
			fcfg_q <= 4'd1;
			relu_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				c3mf_pkg::CFG_NUM_CH:  ncfg_q <= cfg_data[8:0];
				c3mf_pkg::CFG_WIDTH:   wcfg_q <= cfg_data;
				c3mf_pkg::CFG_HEIGHT:  hcfg_q <= cfg_data;
				c3mf_pkg::CFG_FILTERS: fcfg_q <= cfg_data[3:0];
				c3mf_pkg::CFG_RELU:    relu_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic [NCH_W-1:0] nch;
	logic [12:0]      wlim, hlim;
	logic [NF_W-1:0]  nf;

	always_comb begin
		if (ncfg_q == 9'd0) nch = NCH_W'(1);
		else if (32'(ncfg_q) > MAX_CHANNELS) nch = NCH_W'(MAX_CHANNELS);
		else nch = NCH_W'(ncfg_q);
		wlim = (wcfg_q < 13'd3) ? 13'd3 : wcfg_q;
		hlim = (hcfg_q < 13'd3) ? 13'd3 : hcfg_q;
		if (fcfg_q == 4'd0) nf = NF_W'(1);
		else if (32'(fcfg_q) > LANES) nf = NF_W'(LANES);
		else nf = NF_W'(fcfg_q);
	end

	// position counters
	logic [CH_W-1:0]  ch_q;
	logic [POS_W-1:0] col_q, row_q;
	logic [1:0]       r3_q;  // row_q mod 3

	logic is_pix, last_ch, col_wrap, row_wrap;
	logic [POS_W-1:0] row_nx;
	logic [31:0]      col_prod;
	logic [LA_W-1:0]  wr_addr, base_nx;

	assign is_pix   = (req_type == c3mf_pkg::REQ_PIXEL);
	assign last_ch  = (32'(ch_q) + 32'd1 >= 32'(nch));
	assign col_wrap = (13'(col_q) + 13'd1 >= wlim);
	assign row_wrap = (13'(row_q) + 13'd1 >= hlim);
	assign row_nx   = row_wrap ? '0 : row_q + POS_W'(1);
	assign col_prod = 32'(col_q) * 32'(nch);
	assign wr_addr  = LA_W'(col_prod + 32'(ch_q));
	assign base_nx  = LA_W'(col_prod - 32'(nch) - 32'(nch));
	assign stat.fire = is_pix && last_ch && (row_q >= POS_W'(2)) && (col_q >= POS_W'(2));

	logic start;
	assign start = ctl.accept && stat.fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q  <= '0;
			col_q <= '0;
			row_q <= '0;
			r3_q  <= 2'd0;
		end else if (ctl.accept && is_pix) begin
			if (last_ch) begin
				ch_q <= '0;
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_nx;
					if (row_nx == '0) r3_q <= 2'd0;
					else r3_q <= (r3_q == 2'd2) ? 2'd0 : r3_q + 2'd1;
				end else begin
					col_q <= col_q + POS_W'(1);
				end
			end else begin
				ch_q <= ch_q + CH_W'(1);
			end
		end
	end

	// context of the position being computed
	logic [LA_W-1:0]  base_q;
	logic [1:0]       pr3_q;
	logic [POS_W-1:0] orow_q, ocol_q;

	always_ff @(posedge clk) begin
		if (start) begin
			base_q <= base_nx;
			pr3_q  <= r3_q;
			orow_q <= row_q - POS_W'(2);
			ocol_q <= col_q - POS_W'(2);
		end
	end

	// tap sequencing: channel, ky, kx in weight-index order
	logic [NCH_W-1:0] cht_q;
	logic [1:0]       ky_q, kx_q;
	logic [WA_W-1:0]  wa_q;

	assign stat.tap_last = (32'(cht_q) + 32'd1 == 32'(nch)) && (ky_q == KMAX) && (kx_q == KMAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cht_q <= '0;
			ky_q  <= 2'd0;
			kx_q  <= 2'd0;
			wa_q  <= '0;
		end else if (start) begin
			cht_q <= '0;
			ky_q  <= 2'd0;
			kx_q  <= 2'd0;
			wa_q  <= '0;
		end else if (ctl.issue) begin
			wa_q <= wa_q + WA_W'(1);
			if (kx_q == KMAX) begin
				kx_q <= 2'd0;
				if (ky_q == KMAX) begin
					ky_q  <= 2'd0;
					cht_q <= cht_q + NCH_W'(1);
				end else begin
					ky_q <= ky_q + 2'd1;
				end
			end else begin
				kx_q <= kx_q + 2'd1;
			end
		end
	end

	logic [LA_W-1:0] kxn;
	logic [2:0]      trow_sum;
	logic [1:0]      trow;

	always_comb begin
		unique case (kx_q)
			2'd0:    kxn = '0;
			2'd1:    kxn = LA_W'(nch);
			default: kxn = LA_W'(32'(nch) + 32'(nch));
		endcase
		// tap row (row - 2 + ky) mod 3 == (row + 1 + ky) mod 3
		trow_sum = 3'(pr3_q) + 3'd1 + 3'(ky_q);
		trow     = (trow_sum >= 3'd3) ? 2'(trow_sum - 3'd3) : trow_sum[1:0];
	end

	// stage 1: addresses
	logic            v_s1, v_s2, v_s3;
	logic [LA_W-1:0] ladr_s1;
	logic [WA_W-1:0] wadr_s1;
	logic [1:0]      rsel_s1, rsel_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ladr_s1 <= base_q + kxn + LA_W'(cht_q);
		wadr_s1 <= wa_q;
		rsel_s1 <= trow;
		rsel_s2 <= rsel_s1;
	end

	// line store: one memory per buffered row
	logic [DW-1:0] lmem [c3mf_pkg::KSIZE][LINE_WORDS];
	logic [DW-1:0] ldat_s2 [c3mf_pkg::KSIZE];

	always_ff @(posedge clk) begin
		if (ctl.accept && is_pix) lmem[r3_q][wr_addr] <= data_value;
		for (int r = 0; r < c3mf_pkg::KSIZE; r++) ldat_s2[r] <= lmem[r][ladr_s1];
	end

	logic signed [DW-1:0] pix_s2;
	assign pix_s2 = signed'(ldat_s2[rsel_s2]);

	// coefficient write decode
	logic [31:0]     cidx_ext;
	logic [WA_W-1:0] cw_addr;
	logic            coef_we, bias_we;

	assign cidx_ext = 32'(coef_index);
	assign cw_addr  = cidx_ext[WA_W-1:0];
	assign coef_we  = ctl.accept && (req_type == c3mf_pkg::REQ_COEF) &&
	                  (32'(filter_sel) < LANES) && (cidx_ext < FWORDS);
	assign bias_we  = ctl.accept && (req_type == c3mf_pkg::REQ_BIAS) &&
	                  (32'(filter_sel) < LANES);

	logic signed [DW-1:0] bias_q [LANES];
	logic signed [DW-1:0] acc_q  [LANES];

	always_ff @(posedge clk) begin
		if (bias_we) bias_q[LN_W'(filter_sel)] <= data_value;
	end

	// MAC lanes: weight memory, multiply (stage 3), accumulate
	for (genvar f = 0; f < LANES; f++) begin : g_lane
		logic [DW-1:0]          wmem [FWORDS];
		logic signed [DW-1:0]   w_s2;
		logic signed [2*DW-1:0] prod_s3;
		logic signed [2*DW-1:0] shp;
		logic signed [DW-1:0]   fin;

		always_ff @(posedge clk) begin
			if (coef_we && (LN_W'(filter_sel) == LN_W'(f))) wmem[cw_addr] <= data_value;
			w_s2    <= signed'(wmem[wadr_s1]);
			prod_s3 <= w_s2 * pix_s2;
		end

		assign shp = prod_s3 >>> FRAC_BITS;  // floor shift
		assign fin = acc_q[f] + bias_q[f];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				acc_q[f] <= '0;
			end else if (start) begin
				acc_q[f] <= '0;
			end else if (v_s3) begin
				acc_q[f] <= acc_q[f] + shp[DW-1:0];
			end else if (ctl.add_bias) begin
				acc_q[f] <= (relu_q && fin[DW-1]) ? '0 : fin;
			end
		end
	end

	// result lane selection
	logic [LN_W-1:0] lane_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lane_q <= '0;
		else if (ctl.lane_clr) lane_q <= '0;
		else if (ctl.lane_inc) lane_q <= lane_q + LN_W'(1);
	end

	assign stat.lane_last = (32'(lane_q) + 32'd1 == 32'(nf));
	assign filter_id        = 3'(lane_q);
	assign out_row          = orow_q;
	assign out_col          = ocol_q;
	assign out_value        = acc_q[lane_q];
	assign last_of_position = stat.lane_last;

endmodule
